[src/plct_pkg.sv]
// ----------------------------------------------------------------------------
// plct_pkg
// Shared types and constants for the piecewise linear color table fill block.
// ----------------------------------------------------------------------------
package plct_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int CB    = 16;          // channel bits
   localparam int IW    = 8;           // iso / index bits
   localparam int DVD_W = CB + 1;      // slope dividend: 2 * |c1 - c0|
   localparam int DVS_W = IW + 1;      // slope divisor: 2 * d
   localparam int Q_W   = CB + 2;      // running value, two's complement
   localparam int R_W   = DVS_W + 1;   // remainder sum before correction

   typedef enum logic [1:0] {
      OP_COLOR  = 2'd0,
      OP_ALPHA  = 2'd1,
      OP_FORGET = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_ORDER = 2'd2
   } stat_type;

   typedef enum logic [1:0] {
      K_NONE  = 2'd0,
      K_COLOR = 2'd1,
      K_ALPHA = 2'd2,
      K_READ  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      BK_CLEAR  = 3'd0,
      BK_IDLE   = 3'd1,
      BK_DIV    = 3'd2,
      BK_SLOPE  = 3'd3,
      BK_FILL   = 3'd4,
      BK_RDWAIT = 3'd5,
      BK_RESP   = 3'd6
   } bk_state_type;

   typedef struct packed {
      op_type        opcode;
      logic [IW-1:0] iso_value;
      logic [CB-1:0] red_in;
      logic [CB-1:0] green_in;
      logic [CB-1:0] blue_in;
      logic [CB-1:0] alpha_in;
      logic [IW-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]    status;
      logic [CB-1:0] red_out;
      logic [CB-1:0] green_out;
      logic [CB-1:0] blue_out;
      logic [CB-1:0] alpha_out;
   } rsp_type;

   // Classified work item; lane 0 is red or alpha, lanes 1 and 2 green, blue.
   typedef struct packed {
      kind_type            kind;
      logic [1:0]          status;
      logic [IW-1:0]       iso0;
      logic [IW-1:0]       span;
      logic [2:0][CB-1:0]  c0;
      logic [2:0][CB-1:0]  c1;
      logic [IW-1:0]       ridx;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } bk_stat_type;

endpackage

[src/plct_ram.sv]
// ----------------------------------------------------------------------------
// plct_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module plct_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/plct_div.sv]
// ----------------------------------------------------------------------------
// plct_div
// Restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module plct_div (
   input  logic                        clock,
   input  logic                        load,
   input  logic                        step,
   input  logic [plct_pkg::DVD_W-1:0]  dividend,
   input  logic [plct_pkg::DVS_W-1:0]  divisor,
   output logic [plct_pkg::DVD_W-1:0]  quotient,
   output logic [plct_pkg::DVS_W-1:0]  remainder
);

   localparam int DVD_W = plct_pkg::DVD_W;
   localparam int DVS_W = plct_pkg::DVS_W;

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W:0]   trial;
   logic             ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      ge     = (trial >= {1'b0, dvs_ff});
      rem_in = ge ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
      quo_in = {quo_ff[DVD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[src/plct_queue.sv]
// ----------------------------------------------------------------------------
// plct_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module plct_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  plct_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output plct_pkg::cmd_type head
);

   plct_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = slot_ff[rd_ptr_ff];

endmodule

[src/plct_front.sv]
// ----------------------------------------------------------------------------
// plct_front
// Accepts items, checks points against the last point of their channel,
// tracks the last points and builds commands for the back part.
// ----------------------------------------------------------------------------
module plct_front #(
   parameter int TABLE_DEPTH = plct_pkg::TABLE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  plct_pkg::req_type         req_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [plct_pkg::IW-1:0]   csr_data,
   input  plct_pkg::bk_stat_type     bk_stat,
   input  logic                      q_full,
   output logic                      q_push,
   output plct_pkg::cmd_type         q_data
);

   localparam int IW = plct_pkg::IW;
   localparam int CB = plct_pkg::CB;
   localparam logic [IW-1:0] TOP_CAP =
      (TABLE_DEPTH - 1 > 255) ? IW'(255) : IW'(TABLE_DEPTH - 1);

   logic [IW-1:0]        top_limit_ff;
   logic                 color_seen_ff, color_seen_in;
   logic [IW-1:0]        color_iso_ff, color_iso_in;
   logic [2:0][CB-1:0]   color_val_ff, color_val_in;
   logic                 alpha_seen_ff, alpha_seen_in;
   logic [IW-1:0]        alpha_iso_ff, alpha_iso_in;
   logic [CB-1:0]        alpha_val_ff, alpha_val_in;
   logic [IW-1:0]        top;
   logic                 accept;
   plct_pkg::cmd_type    cmd;
   logic [2:0][CB-1:0]   col;

   assign csr_ready = 1'b1;
   assign req_stall = q_full | bk_stat.clearing;
   assign accept    = req_valid & ~req_stall;
   assign q_push    = accept;
   assign q_data    = cmd;

   always_comb begin
      top = (top_limit_ff > TOP_CAP) ? TOP_CAP : top_limit_ff;
      col = {req_data.blue_in, req_data.green_in, req_data.red_in};

      cmd           = '0;
      cmd.kind      = plct_pkg::K_NONE;
      cmd.status    = plct_pkg::ST_OK;
      cmd.ridx      = req_data.read_index;
      color_seen_in = color_seen_ff;
      color_iso_in  = color_iso_ff;
      color_val_in  = color_val_ff;
      alpha_seen_in = alpha_seen_ff;
      alpha_iso_in  = alpha_iso_ff;
      alpha_val_in  = alpha_val_ff;

      case (req_data.opcode)
         plct_pkg::OP_COLOR: begin
            if (req_data.iso_value > top) begin
               cmd.status = plct_pkg::ST_RANGE;
            end else if (color_seen_ff && req_data.iso_value < color_iso_ff) begin
               cmd.status = plct_pkg::ST_ORDER;
            end else begin
               if (color_seen_ff) begin
                  cmd.kind = plct_pkg::K_COLOR;
                  cmd.iso0 = color_iso_ff;
                  cmd.span = req_data.iso_value - color_iso_ff;
                  cmd.c0   = color_val_ff;
                  cmd.c1   = col;
               end
               color_seen_in = 1'b1;
               color_iso_in  = req_data.iso_value;
               color_val_in  = col;
            end
         end
         plct_pkg::OP_ALPHA: begin
            if (req_data.iso_value > top) begin
               cmd.status = plct_pkg::ST_RANGE;
            end else if (alpha_seen_ff && req_data.iso_value < alpha_iso_ff) begin
               cmd.status = plct_pkg::ST_ORDER;
            end else begin
               if (alpha_seen_ff) begin
                  cmd.kind  = plct_pkg::K_ALPHA;
                  cmd.iso0  = alpha_iso_ff;
                  cmd.span  = req_data.iso_value - alpha_iso_ff;
                  cmd.c0[0] = alpha_val_ff;
                  cmd.c1[0] = req_data.alpha_in;
               end
               alpha_seen_in = 1'b1;
               alpha_iso_in  = req_data.iso_value;
               alpha_val_in  = req_data.alpha_in;
            end
         end
         plct_pkg::OP_FORGET: begin
            color_seen_in = 1'b0;
            color_iso_in  = '0;
            color_val_in  = '0;
            alpha_seen_in = 1'b0;
            alpha_iso_in  = '0;
            alpha_val_in  = '0;
         end
         plct_pkg::OP_READ: begin
            if (req_data.read_index > top) begin
               cmd.status = plct_pkg::ST_RANGE;
            end else begin
               cmd.kind = plct_pkg::K_READ;
            end
         end
         default: begin
            cmd.kind = plct_pkg::K_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_limit_ff  <= IW'(255);
         color_seen_ff <= 1'b0;
         color_iso_ff  <= '0;
         color_val_ff  <= '0;
         alpha_seen_ff <= 1'b0;
         alpha_iso_ff  <= '0;
         alpha_val_ff  <= '0;
      end else begin
         if (csr_valid) begin
            top_limit_ff <= csr_data;
         end
         if (accept) begin
            color_seen_ff <= color_seen_in;
            color_iso_ff  <= color_iso_in;
            color_val_ff  <= color_val_in;
            alpha_seen_ff <= alpha_seen_in;
            alpha_iso_ff  <= alpha_iso_in;
            alpha_val_ff  <= alpha_val_in;
         end
      end
   end

endmodule

[src/plct_back.sv]
// ----------------------------------------------------------------------------
// plct_back
// Carries out commands: clears the tables after reset, fills a segment by
// stepping a slope (quotient plus remainder) entry by entry, serves reads.
// ----------------------------------------------------------------------------
module plct_back #(
   parameter int TABLE_DEPTH = plct_pkg::TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  plct_pkg::cmd_type     q_cmd,
   output logic                  q_pop,
   output plct_pkg::bk_stat_type bk_stat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output plct_pkg::rsp_type     rsp_data
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CB    = plct_pkg::CB;
   localparam int IW    = plct_pkg::IW;
   localparam int DVD_W = plct_pkg::DVD_W;
   localparam int DVS_W = plct_pkg::DVS_W;
   localparam int Q_W   = plct_pkg::Q_W;
   localparam int R_W   = plct_pkg::R_W;
   localparam int DC_W  = $clog2(DVD_W);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

   plct_pkg::bk_state_type state_ff, state_in;
   plct_pkg::cmd_type      cmd_ff;
   plct_pkg::rsp_type      res_ff, rsp_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]          addr_ff;
   logic [IW-1:0]          t_ff;
   logic [DC_W-1:0]        divcnt_ff;
   logic [2:0][Q_W-1:0]    q_ff, qs_ff, q_in, qs_in;
   logic [2:0][DVS_W-1:0]  r_ff, rs_ff, r_in, rs_in;
   logic [2:0][DVD_W-1:0]  dividend, quotient;
   logic [2:0][DVS_W-1:0]  remainder;
   logic [DVS_W-1:0]       head_two_d, two_d;
   logic [R_W-1:0]         r_sum;
   logic                   wrap;
   logic                   out_free, fill_kind, div_load, div_step;
   logic                   color_we, alpha_we;
   logic [AW-1:0]          ram_addr;
   logic [3*CB-1:0]        color_wdata, color_rdata;
   logic [CB-1:0]          alpha_wdata, alpha_rdata;

   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign fill_kind  = (q_cmd.kind == plct_pkg::K_COLOR) || (q_cmd.kind == plct_pkg::K_ALPHA);
   assign head_two_d = {q_cmd.span, 1'b0};
   assign two_d      = {cmd_ff.span, 1'b0};

   // Slope dividers, one per lane
   for (genvar l = 0; l < 3; l++) begin : g_lane
      assign dividend[l] = (q_cmd.c1[l] >= q_cmd.c0[l])
                           ? {q_cmd.c1[l] - q_cmd.c0[l], 1'b0}
                           : {q_cmd.c0[l] - q_cmd.c1[l], 1'b0};
      plct_div u_div (
         .clock     (clock),
         .load      (div_load),
         .step      (div_step),
         .dividend  (dividend[l]),
         .divisor   (head_two_d),
         .quotient  (quotient[l]),
         .remainder (remainder[l])
      );
   end

   // Floor slope and the per-entry step of each lane
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (cmd_ff.c1[l] >= cmd_ff.c0[l]) begin
            qs_in[l] = Q_W'(quotient[l]);
            rs_in[l] = remainder[l];
         end else if (remainder[l] == '0) begin
            qs_in[l] = Q_W'(0) - Q_W'(quotient[l]);
            rs_in[l] = '0;
         end else begin
            qs_in[l] = Q_W'(0) - Q_W'(quotient[l]) - Q_W'(1);
            rs_in[l] = two_d - remainder[l];
         end
         r_sum = R_W'(r_ff[l]) + R_W'(rs_ff[l]);
         wrap  = (r_sum >= R_W'(two_d));
         r_in[l] = wrap ? DVS_W'(r_sum - R_W'(two_d)) : DVS_W'(r_sum);
         q_in[l] = q_ff[l] + qs_ff[l] + Q_W'(wrap);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plct_pkg::BK_CLEAR: begin
            if (addr_ff == LAST_ADDR) state_in = plct_pkg::BK_IDLE;
         end
         plct_pkg::BK_IDLE: begin
            if (q_valid) begin
               if (fill_kind) begin
                  state_in = (q_cmd.span == '0) ? plct_pkg::BK_FILL : plct_pkg::BK_DIV;
               end else if (q_cmd.kind == plct_pkg::K_READ) begin
                  state_in = plct_pkg::BK_RDWAIT;
               end else begin
                  state_in = plct_pkg::BK_RESP;
               end
            end
         end
         plct_pkg::BK_DIV: begin
            if (divcnt_ff == DC_W'(DVD_W - 1)) state_in = plct_pkg::BK_SLOPE;
         end
         plct_pkg::BK_SLOPE:  state_in = plct_pkg::BK_FILL;
         plct_pkg::BK_FILL: begin
            if (t_ff == cmd_ff.span) state_in = plct_pkg::BK_RESP;
         end
         plct_pkg::BK_RDWAIT: state_in = plct_pkg::BK_RESP;
         plct_pkg::BK_RESP: begin
            if (out_free) state_in = plct_pkg::BK_IDLE;
         end
         default: state_in = plct_pkg::BK_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      q_pop            = (state_ff == plct_pkg::BK_IDLE) && q_valid;
      div_load         = q_pop && fill_kind;
      div_step         = (state_ff == plct_pkg::BK_DIV);
      bk_stat.clearing = (state_ff == plct_pkg::BK_CLEAR);
      ram_addr         = (state_ff == plct_pkg::BK_IDLE) ? AW'(q_cmd.ridx) : addr_ff;
      color_we         = (state_ff == plct_pkg::BK_CLEAR) ||
                         ((state_ff == plct_pkg::BK_FILL) && (cmd_ff.kind == plct_pkg::K_COLOR));
      alpha_we         = (state_ff == plct_pkg::BK_CLEAR) ||
                         ((state_ff == plct_pkg::BK_FILL) && (cmd_ff.kind == plct_pkg::K_ALPHA));
      if (state_ff == plct_pkg::BK_CLEAR) begin
         color_wdata = '0;
         alpha_wdata = '0;
      end else begin
         color_wdata = {q_ff[2][CB-1:0], q_ff[1][CB-1:0], q_ff[0][CB-1:0]};
         alpha_wdata = q_ff[0][CB-1:0];
      end
      rsp_valid_in = (state_ff == plct_pkg::BK_RESP) ? 1'b1
                   : (rsp_valid_ff & rsp_stall);
   end

   plct_ram #(.WIDTH(3 * CB), .DEPTH(TABLE_DEPTH)) u_color_ram (
      .clock   (clock),
      .wr_en   (color_we),
      .addr    (ram_addr),
      .wr_data (color_wdata),
      .rd_data (color_rdata)
   );

   plct_ram #(.WIDTH(CB), .DEPTH(TABLE_DEPTH)) u_alpha_ram (
      .clock   (clock),
      .wr_en   (alpha_we),
      .addr    (ram_addr),
      .wr_data (alpha_wdata),
      .rd_data (alpha_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plct_pkg::BK_CLEAR;
         rsp_valid_ff <= 1'b0;
         addr_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            plct_pkg::BK_CLEAR: addr_ff <= addr_ff + AW'(1);
            plct_pkg::BK_IDLE: begin
               if (q_valid) begin
                  addr_ff <= AW'(q_cmd.iso0);
               end
            end
            plct_pkg::BK_FILL: addr_ff <= addr_ff + AW'(1);
            default: addr_ff <= addr_ff;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         plct_pkg::BK_IDLE: begin
            if (q_valid) begin
               cmd_ff    <= q_cmd;
               t_ff      <= '0;
               divcnt_ff <= '0;
               res_ff    <= {q_cmd.status, (4 * CB)'(0)};
               for (int l = 0; l < 3; l++) begin
                  q_ff[l] <= (q_cmd.span == '0) ? Q_W'(q_cmd.c1[l]) : Q_W'(q_cmd.c0[l]);
                  r_ff[l] <= DVS_W'(q_cmd.span);
               end
            end
         end
         plct_pkg::BK_DIV: divcnt_ff <= divcnt_ff + DC_W'(1);
         plct_pkg::BK_SLOPE: begin
            qs_ff <= qs_in;
            rs_ff <= rs_in;
         end
         plct_pkg::BK_FILL: begin
            t_ff <= t_ff + IW'(1);
            q_ff <= q_in;
            r_ff <= r_in;
         end
         plct_pkg::BK_RDWAIT: begin
            res_ff.red_out   <= color_rdata[CB-1:0];
            res_ff.green_out <= color_rdata[2*CB-1:CB];
            res_ff.blue_out  <= color_rdata[3*CB-1:2*CB];
            res_ff.alpha_out <= alpha_rdata;
         end
         default: begin
            t_ff <= t_ff;
         end
      endcase
      if ((state_ff == plct_pkg::BK_RESP) && out_free) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/piecewise_linear_color_table_fill_top.sv]
// ----------------------------------------------------------------------------
// A point with fill distance d > 0 runs the bit-serial slope divider, then the
// slope state, then writes every entry from the last point up to the new one;
// an equal-iso point writes its single entry without dividing.
// Throughput: one item at a time in the back part, set by the fill loop and
// the bit-serial slope divider; up to two more items wait in the queue.
// After synchronous reset a clearing pass over every TABLE_DEPTH entry zeroes
// both tables while req_stall is held high. CSR writes are taken throughout.
// ----------------------------------------------------------------------------
// piecewise_linear_color_table_fill_top
// Color and alpha lookup table filled by linear interpolation between
// control points as they arrive.
// ----------------------------------------------------------------------------
module piecewise_linear_color_table_fill_top #(
   parameter int TABLE_DEPTH = plct_pkg::TABLE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  plct_pkg::req_type       req_data,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output plct_pkg::rsp_type       rsp_data,
   // table limit register write
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [plct_pkg::IW-1:0] csr_data
);

   plct_pkg::cmd_type     push_cmd, head_cmd;
   plct_pkg::bk_stat_type bk_stat;
   logic                  q_push, q_full, q_valid, q_pop;

   // Front: check each point against its channel, advance last-point state
   plct_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .bk_stat   (bk_stat),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (push_cmd)
   );

   // Queue: hold classified commands so each side can stall on its own
   plct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (head_cmd)
   );

   // Back: clear, fill segments, serve reads, register each result
   plct_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (head_cmd),
      .q_pop     (q_pop),
      .bk_stat   (bk_stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[verif/piecewise_linear_color_table_fill_top_tb.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_color_table_fill_top_tb
// Self-checking bench for the color table fill block. A local model of both
// interpolation tables predicts every result; directed tests cover the edges
// of each field and each special case, then random point sequences run with
// bursty input traffic and a patterned output stall.
// ----------------------------------------------------------------------------
module piecewise_linear_color_table_fill_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int CB = plct_pkg::CB;
   localparam int IW = plct_pkg::IW;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   plct_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   plct_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [IW-1:0]     csr_data = '0;

   piecewise_linear_color_table_fill_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Table model: state mirrors the block, updated per accepted transfer.
   logic [2:0][CB-1:0] color_mem [256];
   logic [CB-1:0]      alpha_mem [256];
   logic               color_seen, alpha_seen;
   logic [IW-1:0]      color_iso, alpha_iso;
   logic [2:0][CB-1:0] color_last;
   logic [CB-1:0]      alpha_last;
   logic [IW-1:0]      density;

   plct_pkg::rsp_type expected_rsps [$];
   int      errors = 0;
   int      sent = 0;
   int      checked = 0;
   int      reads = 0;
   int      rejects = 0;
   int      idle_cycles = 0;
   logic    stall_random = 1'b1;

   // Interpolate between two channel values, rounding halves up.
   function automatic logic [CB-1:0] lerp_value(logic [CB-1:0] c0, logic [CB-1:0] c1,
                                                int unsigned t, int unsigned d);
      longint unsigned n;
      n = longint'(c0) * (d - t) + longint'(c1) * t;
      return CB'((2 * n + d) / (2 * longint'(d)));
   endfunction

   function automatic plct_pkg::rsp_type predict_table(plct_pkg::req_type r);
      plct_pkg::rsp_type res;
      res = '0;
      case (r.opcode)
         plct_pkg::OP_COLOR: begin
            if (r.iso_value > density) res.status = plct_pkg::ST_RANGE;
            else if (color_seen && r.iso_value < color_iso) res.status = plct_pkg::ST_ORDER;
            else begin
               if (color_seen)
                  for (int x = color_iso; x <= r.iso_value; x++) begin
                     color_mem[x][0] = (r.iso_value == color_iso) ? r.red_in :
                        lerp_value(color_last[0], r.red_in, x - color_iso, r.iso_value - color_iso);
                     color_mem[x][1] = (r.iso_value == color_iso) ? r.green_in :
                        lerp_value(color_last[1], r.green_in, x - color_iso, r.iso_value - color_iso);
                     color_mem[x][2] = (r.iso_value == color_iso) ? r.blue_in :
                        lerp_value(color_last[2], r.blue_in, x - color_iso, r.iso_value - color_iso);
                  end
               color_seen = 1'b1;
               color_iso  = r.iso_value;
               color_last = {r.blue_in, r.green_in, r.red_in};
            end
         end
         plct_pkg::OP_ALPHA: begin
            if (r.iso_value > density) res.status = plct_pkg::ST_RANGE;
            else if (alpha_seen && r.iso_value < alpha_iso) res.status = plct_pkg::ST_ORDER;
            else begin
               if (alpha_seen)
                  for (int x = alpha_iso; x <= r.iso_value; x++)
                     alpha_mem[x] = (r.iso_value == alpha_iso) ? r.alpha_in :
                        lerp_value(alpha_last, r.alpha_in, x - alpha_iso, r.iso_value - alpha_iso);
               alpha_seen = 1'b1;
               alpha_iso  = r.iso_value;
               alpha_last = r.alpha_in;
            end
         end
         plct_pkg::OP_FORGET: begin
            color_seen = 1'b0; color_iso = '0; color_last = '0;
            alpha_seen = 1'b0; alpha_iso = '0; alpha_last = '0;
         end
         default: begin
            if (r.read_index > density) res.status = plct_pkg::ST_RANGE;
            else begin
               res.red_out   = color_mem[r.read_index][0];
               res.green_out = color_mem[r.read_index][1];
               res.blue_out  = color_mem[r.read_index][2];
               res.alpha_out = alpha_mem[r.read_index];
            end
         end
      endcase
      return res;
   endfunction

   // Hold the payload until the transfer completes; valid stays high so the
   // next item can follow right away, and whoever idles the sender drops it.
   task automatic send_item(plct_pkg::req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      expected_rsps.insert(expected_rsps.size(), predict_table(r));
      sent++;
      if (r.opcode == plct_pkg::OP_READ) reads++;
   endtask

   // Gap of random length between bursts.
   task automatic maybe_gap();
      if ($urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_density(logic [IW-1:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      density = v;
   endtask

   function automatic plct_pkg::req_type make_item(plct_pkg::op_type op, int iso, int rgb,
                                                   int a, int idx);
      plct_pkg::req_type r;
      r.opcode = op; r.iso_value = IW'(iso); r.read_index = IW'(idx);
      r.red_in = CB'(rgb); r.green_in = CB'(~rgb); r.blue_in = CB'(rgb ^ 'h5a5a);
      r.alpha_in = CB'(a);
      return r;
   endfunction

   function automatic plct_pkg::req_type random_item(plct_pkg::op_type op, int iso);
      plct_pkg::req_type r;
      r.opcode = op; r.iso_value = IW'(iso);
      r.red_in = CB'($urandom); r.green_in = CB'($urandom); r.blue_in = CB'($urandom);
      r.alpha_in = CB'($urandom); r.read_index = IW'($urandom_range(0, density));
      if ($urandom_range(0, 15) == 0) r.read_index = IW'($urandom);
      return r;
   endfunction

   task automatic read_all();
      for (int i = 0; i <= density; i++)
         send_item(make_item(plct_pkg::OP_READ, 0, 0, 0, i));
   endtask

   // Extremes, both channels, equal iso, rejections, forget, reads.
   task automatic test_directed();
      send_item(make_item(plct_pkg::OP_READ, 0, 0, 0, 255));
      send_item(make_item(plct_pkg::OP_COLOR, 0, 16'h0000, 16'hffff, 0));
      send_item(make_item(plct_pkg::OP_COLOR, 255, 16'hffff, 0, 0));
      send_item(make_item(plct_pkg::OP_ALPHA, 0, 0, 16'hffff, 0));
      send_item(make_item(plct_pkg::OP_ALPHA, 3, 0, 16'h0000, 0));
      send_item(make_item(plct_pkg::OP_ALPHA, 3, 0, 16'h1234, 0));
      send_item(make_item(plct_pkg::OP_ALPHA, 2, 0, 16'h1, 0));
      send_item(make_item(plct_pkg::OP_COLOR, 100, 16'h7, 0, 0));
      send_item(make_item(plct_pkg::OP_FORGET, 0, 0, 0, 0));
      send_item(make_item(plct_pkg::OP_ALPHA, 200, 0, 16'h8000, 0));
      send_item(make_item(plct_pkg::OP_ALPHA, 201, 0, 16'h8001, 0));
      for (int i = 0; i < 4; i++) send_item(make_item(plct_pkg::OP_READ, 0, 0, 0, i));
      send_item(make_item(plct_pkg::OP_READ, 0, 0, 0, 200));
      send_item(make_item(plct_pkg::OP_READ, 0, 0, 0, 201));
      send_item(make_item(plct_pkg::OP_READ, 0, 0, 0, 128));
   endtask

   // Small table settings, including the one-entry table.
   task automatic test_density_edges();
      write_density(8'd0);
      send_item(make_item(plct_pkg::OP_FORGET, 0, 0, 0, 0));
      send_item(make_item(plct_pkg::OP_COLOR, 1, 16'h1111, 0, 0));
      send_item(make_item(plct_pkg::OP_COLOR, 0, 16'h2222, 0, 0));
      send_item(make_item(plct_pkg::OP_COLOR, 0, 16'h3333, 0, 0));
      send_item(make_item(plct_pkg::OP_READ, 0, 0, 0, 0));
      send_item(make_item(plct_pkg::OP_READ, 0, 0, 0, 1));
      write_density(8'd1);
      send_item(make_item(plct_pkg::OP_ALPHA, 0, 0, 16'hffff, 0));
      send_item(make_item(plct_pkg::OP_ALPHA, 1, 0, 16'h0, 0));
      read_all();
   endtask

   // Mostly ordered point sequences with random values, some noise.
   task automatic test_random(int count, logic [IW-1:0] dens);
      int iso_c, iso_a, k;
      write_density(dens);
      iso_c = 0; iso_a = 0;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 19);
         if (k < 5) begin
            if (iso_c > density || $urandom_range(0, 9) == 0) begin
               send_item(make_item(plct_pkg::OP_FORGET, 0, 0, 0, 0));
               iso_c = 0; iso_a = 0;
            end
            send_item(random_item(plct_pkg::OP_COLOR, iso_c));
            iso_c += $urandom_range(0, (density < 16) ? 2 : 24);
         end else if (k < 9) begin
            send_item(random_item(plct_pkg::OP_ALPHA, iso_a));
            iso_a += $urandom_range(0, (density < 16) ? 2 : 24);
         end else if (k < 11) begin
            send_item(random_item(plct_pkg::op_type'($urandom_range(0, 1)), int'($urandom)));
         end else if (k == 11) begin
            send_item(random_item(plct_pkg::OP_FORGET, int'($urandom)));
            iso_c = 0; iso_a = 0;
         end else begin
            send_item(random_item(plct_pkg::OP_READ, int'($urandom)));
         end
         maybe_gap();
      end
   endtask

   // Receiver stall pattern: random phases with stall-free stretches.
   always @(posedge clock) begin
      if (stall_random) rsp_stall <= ($urandom_range(0, 3) == 0);
      else rsp_stall <= 1'b0;
      if ($urandom_range(0, 199) == 0) stall_random <= ~stall_random;
   end

   // Compare each result transfer with the oldest prediction.
   always @(posedge clock) begin
      plct_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result transfer %p", rsp_data);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            checked++;
            if (want.status != plct_pkg::ST_OK) rejects++;
            if (rsp_data.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, rsp_data.status); errors++;
            end
            if (rsp_data.red_out !== want.red_out) begin
               $error("red_out exp %h got %h", want.red_out, rsp_data.red_out); errors++;
            end
            if (rsp_data.green_out !== want.green_out) begin
               $error("green_out exp %h got %h", want.green_out, rsp_data.green_out);
               errors++;
            end
            if (rsp_data.blue_out !== want.blue_out) begin
               $error("blue_out exp %h got %h", want.blue_out, rsp_data.blue_out); errors++;
            end
            if (rsp_data.alpha_out !== want.alpha_out) begin
               $error("alpha_out exp %h got %h", want.alpha_out, rsp_data.alpha_out);
               errors++;
            end
         end
      end
   end

   // Watchdog: count cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d results pending", expected_rsps.size());
         $display("** piecewise_linear_color_table_fill_top: FAILED **");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 256; i++) begin
         color_mem[i] = '0; alpha_mem[i] = '0;
      end
      color_seen = 1'b0; alpha_seen = 1'b0; color_iso = '0; alpha_iso = '0;
      color_last = '0; alpha_last = '0; density = 8'd255;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_density_edges();
      test_random(500, 8'd255);
      test_random(300, 8'd9);
      test_random(300, 8'd128);
      write_density(8'd255);
      test_random(200, 8'd255);
      wait_drained();
      $display("covered %0d items (%0d reads, %0d rejected) over densities 0..255",
               sent, reads, rejects);
      if (errors == 0 && checked == sent)
         $display("** piecewise_linear_color_table_fill_top: PASSED **");
      else
         $display("** piecewise_linear_color_table_fill_top: FAILED **");
      $finish;
   end
endmodule

[filelist.f]
src/plct_pkg.sv
src/plct_ram.sv
src/plct_div.sv
src/plct_queue.sv
src/plct_front.sv
src/plct_back.sv
src/piecewise_linear_color_table_fill_top.sv
verif/piecewise_linear_color_table_fill_top_tb.sv
